### sv/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

   // Screen geometry and store addressing.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int ENTRY_W = 16;
   localparam int COLOR_W = 4;

   // Cell written by clear and by the scroll blanking: a space in white on black.
   localparam logic [ENTRY_W-1:0] BLANK_ENTRY = 16'h0F20;
   localparam logic [7:0]         CHAR_SPACE  = 8'h20;

   // Control characters recognised by put character.
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_RETURN    = 8'd13;

   // Configuration register indexes.
   localparam logic CSR_FOREGROUND = 1'b0;
   localparam logic CSR_BACKGROUND = 1'b1;

   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_SET   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_COPY,
      ST_BLANK
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic copy_step;
      logic blank_step;
      logic respond;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      logic     scroll_need;
      logic     cnt_last;
   } status_type;

endpackage

`default_nettype wire

### sv/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire tcw_pkg::status_type status,
   output tcw_pkg::cmd_type        cmd
);
   import tcw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            case (status.mode)
               MODE_PUT: begin
                  if (status.scroll_need) begin
                     state_in = ST_COPY;
                  end else begin
                     cmd.respond = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
               MODE_SET: begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end
               MODE_CLEAR: begin
                  state_in = ST_BLANK;
               end
               MODE_READ: begin
                  state_in = ST_READ;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            cmd.blank_step = 1'b1;
            if (status.cnt_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/tcw_datapath.sv
`default_nettype none

module tcw_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [1:0]                     req_mode,
   input  wire logic [7:0]                     req_char_code,
   input  wire logic [tcw_pkg::ROW_W-1:0]      req_row_in,
   input  wire logic [tcw_pkg::COL_W-1:0]      req_col_in,
   input  wire logic [tcw_pkg::ADDR_W-1:0]     req_cell_index,
   input  wire logic                           csr_wr_en,
   input  wire logic                           csr_index,
   input  wire logic [tcw_pkg::COLOR_W-1:0]    csr_wr_data,
   input  wire tcw_pkg::cmd_type               cmd,
   output tcw_pkg::status_type                 status,
   output logic                                rsp_valid,
   output logic [tcw_pkg::ROW_W-1:0]           rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]           rsp_cursor_col,
   output logic [tcw_pkg::ADDR_W-1:0]          rsp_cursor_position,
   output logic [tcw_pkg::ENTRY_W-1:0]         rsp_cell_entry,
   output logic                                rsp_scrolled
);
   import tcw_pkg::*;

   localparam logic [ADDR_W-1:0] COLUMNS_A    = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] CELLS_A      = ADDR_W'(CELLS);
   localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_A   = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ROW_W:0]    ROWS_R       = (ROW_W + 1)'(ROWS);
   localparam logic [ROW_W-1:0]  ROW_MAX      = ROW_W'(ROWS - 1);
   localparam logic [COL_W:0]    COLUMNS_C    = (COL_W + 1)'(COLUMNS);
   localparam logic [COL_W-1:0]  COL_MAX      = COL_W'(COLUMNS - 1);

   // Colour registers.
   logic [COLOR_W-1:0] fg_ff;
   logic [COLOR_W-1:0] bg_ff;

   // Captured request.
   mode_type           mode_ff;
   logic [7:0]         char_ff;
   logic [ROW_W-1:0]   row_req_ff;
   logic [COL_W-1:0]   col_req_ff;
   logic [ADDR_W-1:0]  idx_ff;

   // Cursor.
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_in;
   logic [COL_W-1:0]   col_in;

   // Sweep counter and the write stage behind the store's read port.
   logic [ADDR_W-1:0]  cnt_ff;
   logic               wr_pend_ff;
   logic               wr_blank_ff;
   logic [ADDR_W-1:0]  wr_addr_ff;
   logic               scrolled_ff;

   // Character store.
   logic [ENTRY_W-1:0] screen_mem_ff [CELLS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // Result registers.
   logic               rsp_valid_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [ADDR_W-1:0]  rsp_pos_ff;
   logic [ENTRY_W-1:0] rsp_entry_ff;
   logic               rsp_scrolled_ff;

   // Put character decode.
   logic [COL_W:0]     tab_col;
   logic [ROW_W:0]     row_inc;
   logic               put_wr;
   logic [COL_W-1:0]   put_col;
   logic [7:0]         put_char;
   logic               scroll_need;
   logic               idx_ok;
   logic [ADDR_W-1:0]  put_addr;
   logic [ADDR_W-1:0]  pos_in;
   logic [7:0]         attr;

   assign attr    = {bg_ff, fg_ff};
   assign row_inc = {1'b0, row_ff} + (ROW_W + 1)'(1);
   assign tab_col = ({1'b0, col_ff} + (COL_W + 1)'(8)) & ~(COL_W + 1)'(7);
   assign idx_ok  = idx_ff < CELLS_A;

   // Cursor update and the cell written by put character.
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      put_wr      = 1'b0;
      put_col     = col_ff;
      put_char    = char_ff;
      scroll_need = 1'b0;
      if (mode_ff == MODE_PUT) begin
         if (char_ff == CHAR_NEWLINE) begin
            col_in      = '0;
            scroll_need = row_inc >= ROWS_R;
            row_in      = scroll_need ? ROW_MAX : row_inc[ROW_W-1:0];
         end else if (char_ff == CHAR_RETURN) begin
            col_in = '0;
         end else if (char_ff == CHAR_TAB) begin
            if (tab_col >= COLUMNS_C) begin
               col_in      = '0;
               scroll_need = row_inc >= ROWS_R;
               row_in      = scroll_need ? ROW_MAX : row_inc[ROW_W-1:0];
            end else begin
               col_in = tab_col[COL_W-1:0];
            end
         end else if (char_ff == CHAR_BACKSPACE) begin
            if (col_ff != '0) begin
               col_in   = col_ff - COL_W'(1);
               put_wr   = 1'b1;
               put_col  = col_ff - COL_W'(1);
               put_char = CHAR_SPACE;
            end
         end else begin
            put_wr = 1'b1;
            if ({1'b0, col_ff} + (COL_W + 1)'(1) >= COLUMNS_C) begin
               col_in      = '0;
               scroll_need = row_inc >= ROWS_R;
               row_in      = scroll_need ? ROW_MAX : row_inc[ROW_W-1:0];
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end else if (mode_ff == MODE_SET) begin
         row_in = (row_req_ff > ROW_MAX) ? ROW_MAX : row_req_ff;
         col_in = (col_req_ff > COL_MAX) ? COL_MAX : col_req_ff;
      end else if (mode_ff == MODE_CLEAR) begin
         row_in = '0;
         col_in = '0;
      end
      if (!cmd.execute) begin
         row_in = row_ff;
         col_in = col_ff;
      end
   end

   assign put_addr = ADDR_W'(row_ff) * COLUMNS_A + ADDR_W'(put_col);
   assign pos_in   = ADDR_W'(row_in) * COLUMNS_A + ADDR_W'(col_in);

   assign status.mode        = mode_ff;
   assign status.scroll_need = scroll_need;
   assign status.cnt_last    = cnt_ff == LAST_CELL;

   // Store port selection: the sweep writes through its stage, put character directly.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = idx_ff;
      if (cmd.copy_step) begin
         mem_re    = 1'b1;
         mem_raddr = cnt_ff;
      end else if (cmd.execute && mode_ff == MODE_READ && idx_ok) begin
         mem_re = 1'b1;
      end
      mem_we    = wr_pend_ff;
      mem_waddr = wr_addr_ff;
      mem_wdata = wr_blank_ff ? BLANK_ENTRY : rd_data_ff;
      if (cmd.execute && put_wr) begin
         mem_we    = 1'b1;
         mem_waddr = put_addr;
         mem_wdata = {attr, put_char};
      end
   end

   // Character store with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem_ff[mem_raddr];
      end
   end

   // Control registers: colours, cursor, sweep stage and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= COLOR_W'(15);
         bg_ff        <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FOREGROUND: fg_ff <= csr_wr_data;
               CSR_BACKGROUND: bg_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
         row_ff       <= row_in;
         col_ff       <= col_in;
         wr_pend_ff   <= cmd.copy_step | cmd.blank_step;
         rsp_valid_ff <= cmd.respond;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= mode_type'(req_mode);
         char_ff    <= req_char_code;
         row_req_ff <= req_row_in;
         col_req_ff <= req_col_in;
         idx_ff     <= req_cell_index;
      end
      if (cmd.execute) begin
         cnt_ff      <= scroll_need ? COLUMNS_A : '0;
         scrolled_ff <= scroll_need;
      end else if (cmd.copy_step) begin
         cnt_ff <= status.cnt_last ? LAST_ROW_A : cnt_ff + ADDR_W'(1);
      end else if (cmd.blank_step) begin
         cnt_ff <= cnt_ff + ADDR_W'(1);
      end
      wr_blank_ff <= cmd.blank_step;
      wr_addr_ff  <= cmd.copy_step ? cnt_ff - COLUMNS_A : cnt_ff;
      if (cmd.respond) begin
         rsp_row_ff      <= row_in;
         rsp_col_ff      <= col_in;
         rsp_pos_ff      <= pos_in;
         rsp_entry_ff    <= (mode_ff == MODE_READ && idx_ok) ? rd_data_ff : '0;
         rsp_scrolled_ff <= (mode_ff == MODE_PUT) && !cmd.execute && scrolled_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_entry      = rsp_entry_ff;
   assign rsp_scrolled        = rsp_scrolled_ff;

endmodule

`default_nettype wire

### sv/text_console_writer.sv
`default_nettype none

// Text console engine with an 80x25 store of 16-bit character cells.
// A request beat is taken at a rising edge with start high and busy low;
// req_mode selects put character, set cursor, clear screen or read cell.
// Each request gives exactly one response beat: rsp_valid is high for one
// cycle with the cursor after the operation, the cell read (zero for other
// operations) and whether the screen scrolled. The receiver cannot stall.
// A put character or set cursor is captured, executed and then answered from
// registered results; a read cell passes through a read state before its
// response. Busy falls while the response is shown, so the next request can
// be taken then. A put character that scrolls copies the store one cell a cycle
// through its single read and write port: 1920 cells copied and 80 blanked.
// Clear writes 2000 cells, one a cycle.
// Colours are written through the csr_ port at any idle time: index 0 sets
// the foreground, index 1 the background nibble of the attribute byte.
// Reset homes the cursor and sets white on black; the store holds unknown
// data until the first clear.
module text_console_writer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_mode,
   input  wire logic [7:0]                   req_char_code,
   input  wire logic [tcw_pkg::ROW_W-1:0]    req_row_in,
   input  wire logic [tcw_pkg::COL_W-1:0]    req_col_in,
   input  wire logic [tcw_pkg::ADDR_W-1:0]   req_cell_index,
   input  wire logic                         csr_wr_en,
   input  wire logic                         csr_index,
   input  wire logic [tcw_pkg::COLOR_W-1:0]  csr_wr_data,
   output logic                              rsp_valid,
   output logic [tcw_pkg::ROW_W-1:0]         rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]         rsp_cursor_col,
   output logic [tcw_pkg::ADDR_W-1:0]        rsp_cursor_position,
   output logic [tcw_pkg::ENTRY_W-1:0]       rsp_cell_entry,
   output logic                              rsp_scrolled
);
   import tcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   tcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Cursor, colours, store and response registers.
   tcw_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_mode),
      .req_char_code       (req_char_code),
      .req_row_in          (req_row_in),
      .req_col_in          (req_col_in),
      .req_cell_index      (req_cell_index),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_entry      (rsp_cell_entry),
      .rsp_scrolled        (rsp_scrolled)
   );

endmodule

`default_nettype wire

### verif/tb_text_console_writer.sv
`timescale 1ns / 100ps

module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int unsigned TAB_STOP    = 8;
   localparam int unsigned PHASE_BEATS = 320;
   localparam int unsigned NUM_PHASES  = 6;

   typedef struct packed {
      mode_type            mode;
      logic [7:0]          char_code;
      logic [ROW_W-1:0]    row_in;
      logic [COL_W-1:0]    col_in;
      logic [ADDR_W-1:0]   cell_index;
   } console_request_type;

   typedef struct packed {
      logic [ROW_W-1:0]    cursor_row;
      logic [COL_W-1:0]    cursor_col;
      logic [ADDR_W-1:0]   cursor_position;
      logic [ENTRY_W-1:0]  cell_entry;
      logic                scrolled;
   } cursor_report_type;

   // Block ports; the inputs are at known values from time zero.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_mode = MODE_PUT;
   logic [7:0]          req_char_code = '0;
   logic [ROW_W-1:0]    req_row_in = '0;
   logic [COL_W-1:0]    req_col_in = '0;
   logic [ADDR_W-1:0]   req_cell_index = '0;
   logic                csr_wr_en = 1'b0;
   logic                csr_index = CSR_FOREGROUND;
   logic [COLOR_W-1:0]  csr_wr_data = '0;
   logic                rsp_valid;
   logic [ROW_W-1:0]    rsp_cursor_row;
   logic [COL_W-1:0]    rsp_cursor_col;
   logic [ADDR_W-1:0]   rsp_cursor_position;
   logic [ENTRY_W-1:0]  rsp_cell_entry;
   logic                rsp_scrolled;

   // Shadow of the console: screen store, cursor and colours.
   logic [ENTRY_W-1:0]  screen_model [CELLS];
   int unsigned         cursor_row_model = 0;
   int unsigned         cursor_col_model = 0;
   logic [COLOR_W-1:0]  foreground_model = 4'd15;
   logic [COLOR_W-1:0]  background_model = 4'd0;

   console_request_type queued_requests [$];
   cursor_report_type   console_reports_due [$];
   console_request_type beat_on_port;
   int unsigned         gap_left = 0;
   logic                next_start;
   logic                no_idle_stretch = 1'b0;
   cursor_report_type   observed;

   int unsigned         accepted_beats = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         scroll_count = 0;
   int unsigned         clear_count = 0;
   int unsigned         read_count = 0;
   int unsigned         colour_settings = 1;

   text_console_writer dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_char_code       (req_char_code),
      .req_row_in          (req_row_in),
      .req_col_in          (req_col_in),
      .req_cell_index      (req_cell_index),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_entry      (rsp_cell_entry),
      .rsp_scrolled        (rsp_scrolled)
   );

   always #5 clock = ~clock;

   // Applies one operation to the shadow console and returns the cursor report it gives.
   function automatic cursor_report_type apply_console_op(console_request_type rq);
      cursor_report_type rep;
      int unsigned    row_n;
      int unsigned    col_n;
      int unsigned    k;
      logic [7:0]     attr;
      rep   = '0;
      row_n = cursor_row_model;
      col_n = cursor_col_model;
      attr  = {background_model, foreground_model};
      case (rq.mode)
         MODE_PUT: begin
            if (rq.char_code == CHAR_NEWLINE) begin
               col_n = 0;
               row_n++;
            end else if (rq.char_code == CHAR_RETURN) begin
               col_n = 0;
            end else if (rq.char_code == CHAR_TAB) begin
               col_n = (col_n + TAB_STOP) & ~(TAB_STOP - 1);
               if (col_n >= COLUMNS) begin
                  col_n = 0;
                  row_n++;
               end
            end else if (rq.char_code == CHAR_BACKSPACE) begin
               // Backspace blanks the cell it lands on; in column zero it does nothing.
               if (col_n > 0) begin
                  col_n--;
                  screen_model[row_n * COLUMNS + col_n] = {attr, CHAR_SPACE};
               end
            end else begin
               screen_model[row_n * COLUMNS + col_n] = {attr, rq.char_code};
               col_n++;
               if (col_n >= COLUMNS) begin
                  col_n = 0;
                  row_n++;
               end
            end
            // Falling off the bottom moves every line up and blanks the last one.
            if (row_n >= ROWS) begin
               for (k = 0; k < CELLS - COLUMNS; k++)
                  screen_model[k] = screen_model[k + COLUMNS];
               for (k = CELLS - COLUMNS; k < CELLS; k++)
                  screen_model[k] = BLANK_ENTRY;
               row_n = ROWS - 1;
               rep.scrolled = 1'b1;
               scroll_count++;
            end
         end
         MODE_SET: begin
            row_n = (rq.row_in > ROWS - 1) ? ROWS - 1 : rq.row_in;
            col_n = (rq.col_in > COLUMNS - 1) ? COLUMNS - 1 : rq.col_in;
         end
         MODE_CLEAR: begin
            for (k = 0; k < CELLS; k++)
               screen_model[k] = BLANK_ENTRY;
            row_n = 0;
            col_n = 0;
            clear_count++;
         end
         MODE_READ: begin
            if (rq.cell_index < CELLS)
               rep.cell_entry = screen_model[rq.cell_index];
            read_count++;
         end
         default: begin
         end
      endcase
      cursor_row_model    = row_n;
      cursor_col_model    = col_n;
      rep.cursor_row      = ROW_W'(row_n);
      rep.cursor_col      = COL_W'(col_n);
      rep.cursor_position = ADDR_W'(row_n * COLUMNS + col_n);
      return rep;
   endfunction

   function automatic console_request_type make_req(mode_type m, logic [7:0] ch,
                                                 logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                                 logic [ADDR_W-1:0] idx);
      console_request_type rq;
      rq.mode       = m;
      rq.char_code  = ch;
      rq.row_in     = r;
      rq.col_in     = c;
      rq.cell_index = idx;
      return rq;
   endfunction

   // Every field random, so unused fields toggle as well.
   function automatic console_request_type random_request();
      return make_req(mode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)),
                      ADDR_W'($urandom_range(0, 2047)));
   endfunction

   // Text bytes with the control characters well represented.
   function automatic logic [7:0] text_byte();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 12)
         return CHAR_NEWLINE;
      else if (p < 16)
         return CHAR_RETURN;
      else if (p < 24)
         return CHAR_TAB;
      else if (p < 32)
         return CHAR_BACKSPACE;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly runs of text and read-backs of the lower lines, with cursor moves and noise.
   task automatic fill_random_requests(int unsigned count);
      int unsigned      pushed;
      int unsigned      pick;
      int unsigned      run_len;
      console_request_type rq;
      pushed = 0;
      while (pushed < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            run_len = $urandom_range(1, 15);
         else if (pick < 70 || pick >= 90)
            run_len = 1;
         else
            run_len = $urandom_range(1, 3);
         repeat (run_len) begin
            rq = random_request();
            if (pick < 55) begin
               rq.mode      = MODE_PUT;
               rq.char_code = text_byte();
            end else if (pick < 70) begin
               rq.mode = MODE_SET;
            end else if (pick < 90) begin
               rq.mode = MODE_READ;
               if ($urandom_range(0, 1))
                  rq.cell_index = ADDR_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
               else if ($urandom_range(0, 3) != 0)
                  rq.cell_index = ADDR_W'($urandom_range(0, CELLS - 1));
            end else if (pick < 93) begin
               rq.mode = MODE_CLEAR;
            end
            queued_requests.push_back(rq);
            pushed++;
         end
      end
   endtask

   // Waits until every beat has been sent and answered, and the block is quiet.
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (queued_requests.size() != 0 || start || busy || console_reports_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_colours(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_FOREGROUND;
      csr_wr_data <= fg;
      @(posedge clock);
      csr_index   <= CSR_BACKGROUND;
      csr_wr_data <= bg;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      foreground_model = fg;
      background_model = bg;
      colour_settings++;
   endtask

   task automatic report_mismatch(string what, cursor_report_type want, cursor_report_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected row %0d col %0d pos %0d cell %h scrolled %0b,",
                  $realtime, what, want.cursor_row, want.cursor_col, want.cursor_position,
                  want.cell_entry, want.scrolled);
         $display("   got row %0d col %0d pos %0d cell %h scrolled %0b",
                  got.cursor_row, got.cursor_col, got.cursor_position, got.cell_entry,
                  got.scrolled);
      end
   endtask

   // Request driver: presents queued beats with a random gap drawn after each one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            console_reports_due.push_back(apply_console_op(beat_on_port));
            accepted_beats++;
            gap_left   = no_idle_stretch ? 0 : $urandom_range(0, 9);
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_requests.size() != 0) begin
               beat_on_port = queued_requests.pop_front();
               req_mode       <= beat_on_port.mode;
               req_char_code  <= beat_on_port.char_code;
               req_row_in     <= beat_on_port.row_in;
               req_col_in     <= beat_on_port.col_in;
               req_cell_index <= beat_on_port.cell_index;
               next_start = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   // Response monitor: each beat is checked against the oldest outstanding report.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         observed.cursor_row      = rsp_cursor_row;
         observed.cursor_col      = rsp_cursor_col;
         observed.cursor_position = rsp_cursor_position;
         observed.cell_entry      = rsp_cell_entry;
         observed.scrolled        = rsp_scrolled;
         if (console_reports_due.size() == 0)
            report_mismatch("response beat with nothing outstanding", '0, observed);
         else if (observed !== console_reports_due[0])
            report_mismatch("response beat differs", console_reports_due[0], observed);
         if (console_reports_due.size() != 0)
            void'(console_reports_due.pop_front());
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset colours: clear first so no unwritten cell is read.
      @(negedge clock);
      queued_requests.push_back(make_req(MODE_CLEAR, 8'd0, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_PUT, 8'd65, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_PUT, 8'hFF, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_PUT, 8'h00, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_READ, 8'd0, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_READ, 8'd0, 0, 0, 1));
      queued_requests.push_back(make_req(MODE_READ, 8'd0, 0, 0, 2));
      queued_requests.push_back(make_req(MODE_PUT, CHAR_TAB, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_PUT, CHAR_BACKSPACE, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_READ, 8'd0, 0, 0, 7));
      queued_requests.push_back(make_req(MODE_PUT, CHAR_RETURN, 0, 0, 0));
      // Backspace in column zero leaves everything alone.
      queued_requests.push_back(make_req(MODE_PUT, CHAR_BACKSPACE, 0, 0, 0));
      // Cursor request beyond the screen saturates at the bottom right corner.
      queued_requests.push_back(make_req(MODE_SET, 8'd0, 31, 127, 0));
      queued_requests.push_back(make_req(MODE_PUT, 8'd90, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_READ, 8'd0, 0, 0, ADDR_W'(CELLS - COLUMNS - 1)));
      queued_requests.push_back(make_req(MODE_READ, 8'd0, 0, 0, ADDR_W'(CELLS - 1)));
      // A tab past the last stop moves to the next line, here with a scroll.
      queued_requests.push_back(make_req(MODE_SET, 8'd0, ROW_W'(ROWS - 1), 72, 0));
      queued_requests.push_back(make_req(MODE_PUT, CHAR_TAB, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_SET, 8'd0, 5, 3, 0));
      queued_requests.push_back(make_req(MODE_PUT, CHAR_NEWLINE, 0, 0, 0));
      // An index past the screen reads as zero.
      queued_requests.push_back(make_req(MODE_READ, 8'd0, 0, 0, 2047));
      queued_requests.push_back(make_req(MODE_SET, 8'd0, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_SET, 8'd0, ROW_W'(ROWS - 1), 0, 0));
      queued_requests.push_back(make_req(MODE_PUT, CHAR_NEWLINE, 0, 0, 0));
      queued_requests.push_back(make_req(MODE_READ, 8'd0, 0, 0, 0));
      wait_until_drained();

      // Random phases, each under its own colours and split by a full drain.
      for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: write_colours(4'd0, 4'd0);
            1: write_colours(4'd15, 4'd15);
            2: write_colours(4'd0, 4'd15);
            5: write_colours(4'd15, 4'd0);
            default: write_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         endcase
         no_idle_stretch = (phase == 2);
         fill_random_requests(PHASE_BEATS / 2);
         wait_until_drained();
         fill_random_requests(PHASE_BEATS / 2);
         wait_until_drained();
      end
      repeat (8) @(posedge clock);

      $display("Checked %0d request beats under %0d colour settings.",
               accepted_beats, colour_settings);
      $display("Seen: %0d scrolls, %0d clears, %0d cell reads, %0d mismatches.",
               scroll_count, clear_count, read_count, mismatch_count);
      if (mismatch_count == 0 && console_reports_due.size() == 0) begin
         $display("text_console_writer: match");
      end else begin
         $display("text_console_writer: mismatch");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #(200_000_000);
      $display("text_console_writer: mismatch");
      $finish;
   end

endmodule
